// File: hdl/shift_xor_hash_base62_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shift-xor hash base-62 encoder.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SHIFT_XOR_HASH_BASE62_ENCODER_TOP_MACROS_SVH
`define SHIFT_XOR_HASH_BASE62_ENCODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SXHB62_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SXHB62_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sxhb62_pkg.sv
// ----------------------------------------------------------------------------
// sxhb62_pkg
// Types, constants and the digit-to-ASCII map of the shift-xor hash
// base-62 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sxhb62_pkg;

    localparam int HASH_W     = 32;
    localparam int HASH_SHIFT = 5;
    localparam int BYTE_W     = 8;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int DIGITS_MAX = 6;
    localparam int BASE       = 62;

    // The base is 2 * 31. This is 2^36 / 31 rounded up, which gives the exact
    // quotient by 31 for any dividend below 2^31.
    localparam logic [HASH_W-1:0] RECIP_HALF_BASE = 32'h8421_0843;
    localparam int                RECIP_SHIFT     = 36;

    localparam int IDX_W     = $clog2(DIGITS_MAX);
    localparam int NUM_W     = $clog2(DIGITS_MAX + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              last_char;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Digits 0-9, then A-Z, then a-z.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_W'(10)) begin
            return dw + CHAR_W'(48);
        end else if (d < DIGIT_W'(36)) begin
            return dw + CHAR_W'(55);
        end else begin
            return dw + CHAR_W'(61);
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/sxhb62_stream_if.sv
// ----------------------------------------------------------------------------
// sxhb62_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sxhb62_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/shift_xor_hash_base62_encoder_top.sv
// ----------------------------------------------------------------------------
// shift_xor_hash_base62_encoder_top
// Running shift-xor string hash with a base-62 short code on string end.
//
// i_in carries one string byte per request (data_byte, byte_valid,
// end_of_string). A request without end_of_string only updates the hash,
// so such requests stream at one per cycle while the encoder is idle.
// A request with end_of_string starts the encoder. One shared reciprocal
// multiplier divides by 62 and yields one digit per cycle; a hash gives
// 1 to 6 digits. The digits are then loaded into the output
// register most significant first, one per cycle unless the receiver stalls,
// with last_char set on the final one. i_in.ready stays low while the
// encoder divides and emits. If the receiver stalls, emission waits; the
// final character may still sit in the output register while the next
// string is already being hashed.
// Reset clears the hash, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shift_xor_hash_base62_encoder_top_macros.svh"

module shift_xor_hash_base62_encoder_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    sxhb62_stream_if.sink   i_in,
    sxhb62_stream_if.source o_out
);
    import sxhb62_pkg::*;

    t_state r_state, n_state;

    logic [HASH_W-1:0]    r_hash, n_hash;
    logic [HASH_W-1:0]    r_quot, n_quot;
    logic [NUM_W-1:0]     r_num_digits, n_num_digits;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic [DIGIT_W-1:0] r_digit_buf [DIGITS_MAX];

    logic [HASH_W-1:0]   hash_upd;
    logic [HASH_W-1:0]   byte_ext;
    logic [2*HASH_W-2:0] recip_prod;
    logic [HASH_W-1:0]   quot_next;
    logic [DIGIT_W-1:0]  rem_digit;
    logic                div_finish;
    logic                buf_we;
    logic                out_load;
    logic                in_fire;
    t_in_item            in_item;

    assign in_item = i_in.payload;
    assign in_fire = i_in.valid && i_in.ready;

    // Hash update: the byte is sign-extended before the xor.
    assign byte_ext = {{(HASH_W-BYTE_W){in_item.data_byte[BYTE_W-1]}}, in_item.data_byte};
    assign hash_upd = in_item.byte_valid
                    ? (r_hash << HASH_SHIFT) + (r_hash ^ byte_ext)
                    : r_hash;

    // A division by 62 is a division of the halved value by 31. The remainder
    // is below 64 and equals h + 2q modulo 64, so six bits of add suffice.
    assign recip_prod = r_quot[HASH_W-1:1] * RECIP_HALF_BASE;
    assign quot_next  = HASH_W'(recip_prod >> RECIP_SHIFT);
    assign rem_digit  = r_quot[DIGIT_W-1:0] + {quot_next[DIGIT_W-2:0], 1'b0};
    assign buf_we     = (r_state == ST_DIV);
    assign div_finish = buf_we
                     && ((quot_next == '0) || (r_num_digits == NUM_W'(DIGITS_MAX-1)));

    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && in_item.end_of_string) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_finish) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && (r_rd_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_hash       = r_hash;
        n_quot       = r_quot;
        n_num_digits = r_num_digits;
        n_rd_idx     = r_rd_idx;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_out.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_item.end_of_string) begin
                        n_hash       = '0;
                        n_quot       = hash_upd;
                        n_num_digits = '0;
                    end else begin
                        n_hash = hash_upd;
                    end
                end
            end
            ST_DIV: begin
                n_quot       = quot_next;
                n_num_digits = r_num_digits + NUM_W'(1);
                n_rd_idx     = r_num_digits[IDX_W-1:0];
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid     = 1'b1;
                    n_out.code_char = digit_to_char(r_digit_buf[r_rd_idx]);
                    n_out.last_char = (r_rd_idx == '0);
                    n_rd_idx        = r_rd_idx - IDX_W'(1);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hash       <= '0;
            r_num_digits <= '0;
            r_rd_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hash       <= n_hash;
            r_num_digits <= n_num_digits;
            r_rd_idx     <= n_rd_idx;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_out  <= n_out;
        if (buf_we) begin
            r_digit_buf[r_num_digits[IDX_W-1:0]] <= rem_digit;
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `SXHB62_ASSERT_SAME(a_digit_below_base, i_clk, i_rst_n, buf_we, rem_digit < DIGIT_W'(BASE), "division remainder reached the base")
    `SXHB62_ASSERT_SAME(a_digit_count, i_clk, i_rst_n, 1'b1, r_num_digits <= NUM_W'(DIGITS_MAX), "digit count beyond six")
    `SXHB62_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, in_fire && in_item.end_of_string, (r_hash == '0) && (r_state == ST_DIV), "end request did not clear hash and start division")

endmodule

`default_nettype wire

// File: tb/tb_shift_xor_hash_base62_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_shift_xor_hash_base62_encoder_top
// Self-checking bench for the shift-xor string hash and base-62 encoder.
// A queue of string requests feeds a clocked driver. Each accepted request
// updates a local copy of the running hash; an end request turns that hash
// into its expected base-62 characters. A clocked monitor compares every
// character that leaves the block, in order. Both sides insert random gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shift_xor_hash_base62_encoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sxhb62_pkg::*;

    localparam int TARGET_REQUESTS = 470;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 250;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sxhb62_stream_if #(.t_payload(t_in_item))  in_if ();
    sxhb62_stream_if #(.t_payload(t_out_item)) out_if ();

    shift_xor_hash_base62_encoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    string digit_alphabet =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    t_in_item  pending_requests[$];
    t_out_item expected_chars[$];
    bit [31:0] running_hash = '0;

    int requests_queued  = 0;
    int hashing_requests = 0;
    int requests_taken   = 0;
    int strings_encoded  = 0;
    int chars_checked    = 0;
    int errors           = 0;
    int cycle_count      = 0;

    int send_gap   = 0;
    int send_calm  = 0;
    int stall_left = 0;
    int stall_calm = 0;

    // Mostly short gaps, a few long ones, and now and then a stretch of none.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            calm = $urandom_range(60, 20);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Applies one accepted request to the local hash and, on a string end,
    // queues the characters that the block must send.
    task automatic absorb_request(input t_in_item req);
        bit [31:0]  sext;
        bit [31:0]  h;
        bit [5:0]   digits[6];
        int         n;
        byte        ch;
        t_out_item  exp_item;
        if (req.byte_valid) begin
            sext = {{24{req.data_byte[7]}}, req.data_byte};
            running_hash = (running_hash << 5) + (running_hash ^ sext);
        end
        if (req.end_of_string) begin
            h = running_hash;
            n = 0;
            do begin
                digits[n] = 6'(h % 62);
                n++;
                h = h / 62;
            end while (h != 0 && n < 6);
            for (int k = n - 1; k >= 0; k--) begin
                ch = digit_alphabet[digits[k]];
                exp_item.code_char = ch[6:0];
                exp_item.last_char = (k == 0);
                expected_chars = {expected_chars, exp_item};
            end
            running_hash = '0;
            strings_encoded++;
        end
    endtask

    task automatic queue_request(input logic [7:0] data, input logic valid, input logic eos);
        t_in_item req;
        req.data_byte     = data;
        req.byte_valid    = valid;
        req.end_of_string = eos;
        pending_requests = {pending_requests, req};
        requests_queued++;
        if (valid || eos) hashing_requests++;
    endtask

    task automatic queue_string(input string s, input bit empty_end);
        for (int i = 0; i < s.len(); i++) begin
            queue_request(s[i], 1'b1, !empty_end && (i == s.len() - 1));
        end
        if (empty_end || s.len() == 0) queue_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic queue_random_string();
        int         len;
        logic [7:0] b;
        bit         empty_end;
        len = ($urandom_range(99) < 80) ? $urandom_range(8) : $urandom_range(24, 9);
        empty_end = (len == 0) || $urandom_range(1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) queue_request(8'($urandom), 1'b0, 1'b0);
            if ($urandom_range(99) < 70) b = 8'($urandom_range(126, 32));
            else b = 8'($urandom);
            queue_request(b, 1'b1, !empty_end && (i == len - 1));
        end
        if (empty_end) queue_request(8'($urandom), 1'b0, 1'b1);
    endtask

    // Request driver: loads the next request once the current one is taken.
    always @(posedge i_clk) begin
        t_in_item nxt_item;
        logic     nxt_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            nxt_valid = in_if.valid;
            nxt_item  = in_if.payload;
            if (in_if.valid && in_if.ready) begin
                absorb_request(in_if.payload);
                requests_taken++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0) begin
                    nxt_item  = pending_requests.pop_front();
                    nxt_valid = 1'b1;
                    send_gap  = pick_gap(send_calm);
                end
            end
            in_if.valid   <= nxt_valid;
            in_if.payload <= nxt_item;
        end
    end

    // Character monitor with random backpressure.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                             $time, out_if.payload.code_char, out_if.payload.last_char);
                    errors++;
                end else begin
                    want = expected_chars.pop_front();
                    if (out_if.payload.code_char !== want.code_char) begin
                        $display("%0t: code_char mismatch: expected %0d, actual %0d",
                                 $time, want.code_char, out_if.payload.code_char);
                        errors++;
                    end
                    if (out_if.payload.last_char !== want.last_char) begin
                        $display("%0t: last_char mismatch: expected %0b, actual %0b",
                                 $time, want.last_char, out_if.payload.last_char);
                        errors++;
                    end
                    chars_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                stall_left = pick_gap(stall_calm);
                out_if.ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d requests taken and %0d characters outstanding",
                     $time, requests_taken, expected_chars.size());
            $display("tb_shift_xor_hash_base62_encoder_top: FAIL");
            $finish;
        end
    end

    initial begin
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;

        // Directed part: extremes, special strings and sign extension.
        queue_request(8'hA5, 1'b0, 1'b0);     // idle request, ignored
        queue_request(8'h3C, 1'b0, 1'b1);     // empty string
        queue_request(8'h00, 1'b1, 1'b1);     // zero byte keeps the hash at zero
        queue_request(8'hFF, 1'b1, 1'b1);     // all ones after sign extension
        queue_request(8'h80, 1'b1, 1'b1);
        queue_request(8'h7F, 1'b1, 1'b1);
        queue_request(8'h01, 1'b1, 1'b1);
        queue_request(8'd61, 1'b1, 1'b1);     // largest single digit
        queue_request(8'd62, 1'b1, 1'b1);     // first two-digit code
        queue_string("hello", 1'b0);
        queue_request(8'h61, 1'b1, 1'b0);
        queue_request(8'h5A, 1'b0, 1'b0);     // idle in the middle of a string
        queue_request(8'h62, 1'b1, 1'b0);
        queue_request(8'h00, 1'b0, 1'b1);
        for (int i = 0; i < 7; i++) queue_request(8'hFF, 1'b1, 1'b0);
        queue_request(8'hC3, 1'b0, 1'b1);

        while (requests_queued < TARGET_REQUESTS) queue_random_string();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken != requests_queued || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_chars.size() != 0) begin
            $display("%0t: %0d expected characters never arrived", $time, expected_chars.size());
            errors++;
        end
        $display("Sent %0d requests, %0d of them hashing or ending a string.",
                 requests_taken, hashing_requests);
        $display("Encoded %0d strings and compared %0d characters, %0d errors.",
                 strings_encoded, chars_checked, errors);
        if (errors == 0) begin
            $display("tb_shift_xor_hash_base62_encoder_top: PASS");
        end else begin
            $display("tb_shift_xor_hash_base62_encoder_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/sxhb62_pkg.sv
hdl/sxhb62_stream_if.sv
hdl/shift_xor_hash_base62_encoder_top.sv
tb/tb_shift_xor_hash_base62_encoder_top.sv
